[src/ringtone_text_note_parser_core_macros.svh]
// ============================================================================
// Ringtone text note parser assertion macros
// Concurrent assertion wrappers clocked on clk and disabled during reset.
// ============================================================================
`ifndef RINGTONE_TEXT_NOTE_PARSER_CORE_MACROS_SVH
`define RINGTONE_TEXT_NOTE_PARSER_CORE_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define RTNP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define RTNP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/rtnp_pkg.sv]
// ============================================================================
// Ringtone text note parser package
// Word types, parser state, controller command and status, and constants.
// ============================================================================
package rtnp_pkg;

    // Input word: one character of the ringtone text
    typedef struct packed {
        logic [7:0] tune_byte;
        logic       first_byte;
        logic       last_byte;
    } tune_word_t;

    // Output word: one parsed note or an end-of-text marker
    typedef struct packed {
        logic        note_present;
        logic [15:0] frequency_hz;
        logic [15:0] duration_ms;
        logic [3:0]  gap_ms;
        logic        tune_done;
    } note_word_t;

    typedef enum logic [1:0] {
        SEC_NAME,
        SEC_HEADER,
        SEC_NOTES
    } section_t;

    typedef enum logic [1:0] {
        KEY_NONE,
        KEY_LEN,
        KEY_OCT,
        KEY_BPM
    } hkey_t;

    typedef enum logic [2:0] {
        PH_SKIP,
        PH_DUR,
        PH_SHARP,
        PH_DOT1,
        PH_OCT,
        PH_DOT2,
        PH_TAIL
    } phase_t;

    // Parser state held between text words
    typedef struct packed {
        section_t    section;
        hkey_t       hkey;
        logic [15:0] hval;
        logic [7:0]  dlen;
        logic [7:0]  doct;
        logic [15:0] tempo;
        phase_t      phase;
        logic [7:0]  nlen;
        logic [7:0]  nletter;
        logic        sharp;
        logic        dot;
        logic        begun;
        logic [3:0]  noct;
    } parse_state_t;

    localparam logic [7:0]  DefLength  = 8'd4;
    localparam logic [7:0]  DefOctave  = 8'd6;
    localparam logic [15:0] DefTempo   = 16'd63;
    localparam logic [17:0] DefWholeMs = 18'd3809;

    // 60000 ms per minute times four beats per whole note
    localparam logic [17:0] WholeBaseMs = 18'd240000;

    localparam logic [18:0] GapThreshMs = 19'd50;
    localparam logic [3:0]  GapLongMs   = 4'd15;
    localparam logic [3:0]  GapShortMs  = 4'd5;

    localparam int unsigned DividendW = 18;
    localparam int unsigned DivisorW  = 16;
    localparam int unsigned DivSteps  = DividendW;
    localparam int unsigned DivCntW   = $clog2(DivSteps + 1);

    localparam parse_state_t ParseReset = '{
        section: SEC_NAME,
        hkey:    KEY_NONE,
        hval:    16'd0,
        dlen:    DefLength,
        doct:    DefOctave,
        tempo:   DefTempo,
        phase:   PH_SKIP,
        nlen:    8'd0,
        nletter: 8'd0,
        sharp:   1'b0,
        dot:     1'b0,
        begun:   1'b0,
        noct:    4'd0
    };

    // Controller to datapath commands
    typedef struct packed {
        logic step;
        logic div_start;
        logic load_whole;
        logic load_out;
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic needs_div;
        logic has_result;
        logic pend_note;
        logic div_done;
        logic out_free;
    } ctrl_status_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) ? (c + 8'd32) : c;
    endfunction

    // Octave-4 pitch of a note letter, zero for a pause or unknown letter
    function automatic logic [8:0] base_pitch(input logic [7:0] letter, input logic sharp);
        logic [8:0] p;
        case (to_lower(letter))
            8'h63:   p = sharp ? 9'd277 : 9'd262;
            8'h64:   p = sharp ? 9'd311 : 9'd294;
            8'h65:   p = 9'd330;
            8'h66:   p = sharp ? 9'd370 : 9'd349;
            8'h67:   p = sharp ? 9'd415 : 9'd392;
            8'h61:   p = sharp ? 9'd466 : 9'd440;
            8'h62:   p = 9'd494;
            default: p = 9'd0;
        endcase
        return p;
    endfunction

endpackage

[src/rtnp_divider.sv]
// ============================================================================
// Ringtone text note parser serial divider
// Restoring unsigned divider, one quotient bit per cycle.
// ============================================================================
module rtnp_divider (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [rtnp_pkg::DividendW-1:0]     dividend,
    input  logic [rtnp_pkg::DivisorW-1:0]      divisor,
    output logic                               done,
    output logic [rtnp_pkg::DividendW-1:0]     quotient
);

    logic [rtnp_pkg::DivCntW-1:0]   cnt_reg,  cnt_next;
    logic [rtnp_pkg::DivisorW-1:0]  rem_reg,  rem_next;
    logic [rtnp_pkg::DividendW-1:0] quo_reg,  quo_next;
    logic [rtnp_pkg::DivisorW-1:0]  dvs_reg,  dvs_next;
    logic [rtnp_pkg::DivisorW:0]    trial;
    logic [rtnp_pkg::DivisorW:0]    diff;

    // Shift in the next dividend bit and subtract where it fits
    always_comb
    begin
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        dvs_next = dvs_reg;
        trial    = {rem_reg, quo_reg[rtnp_pkg::DividendW-1]};
        diff     = trial - {1'b0, dvs_reg};
        if (start)
        begin
            cnt_next = rtnp_pkg::DivCntW'(rtnp_pkg::DivSteps);
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = diff[rtnp_pkg::DivisorW-1:0];
                quo_next = {quo_reg[rtnp_pkg::DividendW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[rtnp_pkg::DivisorW-1:0];
                quo_next = {quo_reg[rtnp_pkg::DividendW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Hold operands and partial results
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = (cnt_reg == '0);
    assign quotient = quo_reg;

endmodule

[src/rtnp_datapath.sv]
// ============================================================================
// Ringtone text note parser datapath
// Byte parser state, note capture, divider and output register.
// ============================================================================
module rtnp_datapath (
    input  logic                    clk,
    input  logic                    rst_n,
    input  rtnp_pkg::ctrl_cmd_t     cmd,
    input  rtnp_pkg::tune_word_t    text_word,
    input  logic                    note_ready,
    output rtnp_pkg::ctrl_status_t  status,
    output logic                    note_valid,
    output rtnp_pkg::note_word_t    note_word
);

    rtnp_pkg::parse_state_t  parse_reg, parse_next;
    logic [17:0]             whole_reg, whole_next;
    logic                    cap_present_reg;
    logic                    cap_done_reg;
    logic                    cap_dot_reg;
    logic [15:0]             cap_freq_reg;
    logic                    out_valid_reg;
    rtnp_pkg::note_word_t    out_word_reg;

    logic                    step_make;
    logic                    step_result;
    logic                    step_need_div;
    logic                    step_dot;
    logic [15:0]             step_freq;
    logic [17:0]             div_dividend;
    logic [15:0]             div_divisor;
    logic                    div_done;
    logic [17:0]             div_quotient;
    logic [18:0]             dur_full;

    // Work out the parser update for one text word
    always_comb
    begin
        rtnp_pkg::parse_state_t s;
        logic [7:0]  c;
        logic [7:0]  lc;
        logic [3:0]  dig;
        logic        handled;
        logic        cont;
        logic        emit_note;
        logic        latch_whole;
        logic [7:0]  len_eff;
        logic [7:0]  oct_eff;
        logic [7:0]  sh;
        logic [8:0]  base;

        c           = text_word.tune_byte;
        lc          = rtnp_pkg::to_lower(c);
        dig         = c[3:0];
        handled     = 1'b0;
        cont        = 1'b1;
        emit_note   = 1'b0;
        latch_whole = 1'b0;
        len_eff     = 8'd0;
        oct_eff     = 8'd0;
        sh          = 8'd0;
        base        = 9'd0;
        s           = text_word.first_byte ? rtnp_pkg::ParseReset : parse_reg;

        case (s.section)
            rtnp_pkg::SEC_NAME:
            begin
                if (c == 8'h3A)
                begin
                    s.section = rtnp_pkg::SEC_HEADER;
                end
            end
            rtnp_pkg::SEC_HEADER:
            begin
                // Accumulate or finish a pending key value
                if (s.hkey != rtnp_pkg::KEY_NONE)
                begin
                    if (rtnp_pkg::is_digit(c))
                    begin
                        s.hval  = (s.hval << 3) + (s.hval << 1) + {12'd0, dig};
                        s.begun = 1'b1;
                        handled = 1'b1;
                    end
                    else if (!s.begun && ((c == 8'h20) || (c == 8'h3D)))
                    begin
                        handled = 1'b1;
                    end
                    else
                    begin
                        if ((s.hkey == rtnp_pkg::KEY_LEN) && (s.hval[7:0] != 8'd0))
                        begin
                            s.dlen = s.hval[7:0];
                        end
                        else if ((s.hkey == rtnp_pkg::KEY_OCT) && (s.hval[7:0] != 8'd0))
                        begin
                            s.doct = s.hval[7:0];
                        end
                        else if ((s.hkey == rtnp_pkg::KEY_BPM) && (s.hval != 16'd0))
                        begin
                            s.tempo = s.hval;
                        end
                        s.hkey  = rtnp_pkg::KEY_NONE;
                        s.hval  = 16'd0;
                        s.sharp = 1'b0;
                        s.dot   = 1'b0;
                        s.begun = 1'b0;
                    end
                end
                // Look at the byte as a new header byte
                if (!handled)
                begin
                    if (c == 8'h3A)
                    begin
                        latch_whole = (s.tempo != 16'd0);
                        s.section   = rtnp_pkg::SEC_NOTES;
                        s.phase     = rtnp_pkg::PH_SKIP;
                        s.sharp     = 1'b0;
                        s.dot       = 1'b0;
                        s.begun     = 1'b0;
                    end
                    else if ((lc == 8'h64) || (lc == 8'h6F) || (lc == 8'h62))
                    begin
                        if (lc == 8'h64)
                        begin
                            s.hkey = rtnp_pkg::KEY_LEN;
                        end
                        else if (lc == 8'h6F)
                        begin
                            s.hkey = rtnp_pkg::KEY_OCT;
                        end
                        else
                        begin
                            s.hkey = rtnp_pkg::KEY_BPM;
                        end
                        s.hval  = 16'd0;
                        s.sharp = 1'b0;
                        s.dot   = 1'b0;
                        s.begun = 1'b0;
                    end
                end
            end
            default:
            begin
                // Walk the note phases, each may pass the byte on to the next
                if (s.phase == rtnp_pkg::PH_SKIP)
                begin
                    if ((c == 8'h20) || (c == 8'h2C))
                    begin
                        cont = 1'b0;
                    end
                    else
                    begin
                        s.nlen    = 8'd0;
                        s.nletter = 8'd0;
                        s.noct    = 4'd0;
                        s.sharp   = 1'b0;
                        s.dot     = 1'b0;
                        s.begun   = 1'b1;
                        s.phase   = rtnp_pkg::PH_DUR;
                    end
                end
                if (cont && (s.phase == rtnp_pkg::PH_DUR))
                begin
                    if (rtnp_pkg::is_digit(c))
                    begin
                        s.nlen = (s.nlen << 3) + (s.nlen << 1) + {4'd0, dig};
                    end
                    else
                    begin
                        s.nletter = c;
                        s.phase   = rtnp_pkg::PH_SHARP;
                    end
                    cont = 1'b0;
                end
                if (cont && (s.phase == rtnp_pkg::PH_SHARP))
                begin
                    s.phase = rtnp_pkg::PH_DOT1;
                    if (c == 8'h23)
                    begin
                        s.sharp = 1'b1;
                        cont    = 1'b0;
                    end
                end
                if (cont && (s.phase == rtnp_pkg::PH_DOT1))
                begin
                    s.phase = rtnp_pkg::PH_OCT;
                    if (c == 8'h2E)
                    begin
                        s.dot = 1'b1;
                        cont  = 1'b0;
                    end
                end
                if (cont && (s.phase == rtnp_pkg::PH_OCT))
                begin
                    s.phase = rtnp_pkg::PH_DOT2;
                    if (rtnp_pkg::is_digit(c))
                    begin
                        s.noct = dig;
                        cont   = 1'b0;
                    end
                end
                if (cont && (s.phase == rtnp_pkg::PH_DOT2))
                begin
                    s.phase = rtnp_pkg::PH_TAIL;
                    if (c == 8'h2E)
                    begin
                        s.dot = 1'b1;
                        cont  = 1'b0;
                    end
                end
                if (cont)
                begin
                    emit_note = (c == 8'h2C);
                end
            end
        endcase

        // A note is made on its comma, or on the last byte once begun
        step_make = emit_note ||
                    (text_word.last_byte && (s.section == rtnp_pkg::SEC_NOTES) &&
                     (s.phase != rtnp_pkg::PH_SKIP));

        // Note pitch and length from the state left by this byte
        len_eff = (s.nlen != 8'd0) ? s.nlen : s.dlen;
        if (len_eff == 8'd0)
        begin
            len_eff = 8'd1;
        end
        oct_eff = (s.noct != 4'd0) ? {4'd0, s.noct} : s.doct;
        base    = rtnp_pkg::base_pitch(s.nletter, s.sharp);
        if (oct_eff >= 8'd4)
        begin
            sh = oct_eff - 8'd4;
            if (sh >= 8'd16)
            begin
                step_freq = 16'd0;
            end
            else
            begin
                step_freq = {7'd0, base} << sh[3:0];
            end
        end
        else
        begin
            step_freq = {7'd0, base} >> (3'd4 - {1'b0, oct_eff[1:0]});
        end
        step_dot = s.dot;

        if (step_make)
        begin
            s.phase = rtnp_pkg::PH_SKIP;
            s.sharp = 1'b0;
            s.dot   = 1'b0;
            s.begun = 1'b0;
        end

        step_result   = step_make || text_word.last_byte;
        step_need_div = step_make || (latch_whole && !text_word.last_byte);

        // Pick the divider operands: note length or whole-note time
        if (step_make)
        begin
            div_dividend = whole_reg;
            div_divisor  = {8'd0, len_eff};
        end
        else
        begin
            div_dividend = rtnp_pkg::WholeBaseMs;
            div_divisor  = s.tempo;
        end

        parse_next = text_word.last_byte ? rtnp_pkg::ParseReset : s;
    end

    rtnp_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Whole-note time: reset on restart or end, latch at the header end
    always_comb
    begin
        whole_next = whole_reg;
        if (cmd.step)
        begin
            if (text_word.first_byte || text_word.last_byte)
            begin
                whole_next = rtnp_pkg::DefWholeMs;
            end
        end
        else if (cmd.load_whole)
        begin
            whole_next = div_quotient;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_reg     <= rtnp_pkg::ParseReset;
            whole_reg     <= rtnp_pkg::DefWholeMs;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.step)
            begin
                parse_reg <= parse_next;
            end
            whole_reg <= whole_next;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (note_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the note fields of the word being worked on
    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            cap_present_reg <= step_make;
            cap_done_reg    <= text_word.last_byte;
            cap_dot_reg     <= step_dot;
            cap_freq_reg    <= step_freq;
        end
    end

    // Duration with the dotted half added, and the output word
    assign dur_full = {1'b0, div_quotient} +
                      (cap_dot_reg ? {2'b00, div_quotient[17:1]} : 19'd0);

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_word_reg.tune_done <= cap_done_reg;
            if (cap_present_reg)
            begin
                out_word_reg.note_present <= 1'b1;
                out_word_reg.frequency_hz <= cap_freq_reg;
                out_word_reg.duration_ms  <= dur_full[15:0];
                out_word_reg.gap_ms       <= (dur_full > rtnp_pkg::GapThreshMs) ?
                                             rtnp_pkg::GapLongMs : rtnp_pkg::GapShortMs;
            end
            else
            begin
                out_word_reg.note_present <= 1'b0;
                out_word_reg.frequency_hz <= 16'd0;
                out_word_reg.duration_ms  <= 16'd0;
                out_word_reg.gap_ms       <= 4'd0;
            end
        end
    end

    assign status.needs_div  = step_need_div;
    assign status.has_result = step_result;
    assign status.pend_note  = cap_present_reg;
    assign status.div_done   = div_done;
    assign status.out_free   = !out_valid_reg || note_ready;

    assign note_valid = out_valid_reg;
    assign note_word  = out_word_reg;

endmodule

[src/rtnp_controller.sv]
// ============================================================================
// Ringtone text note parser controller
// Sequences text word acceptance, divider runs and result loads.
// ============================================================================
module rtnp_controller (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    text_valid,
    output logic                    text_ready,
    input  rtnp_pkg::ctrl_status_t  status,
    output rtnp_pkg::ctrl_cmd_t     cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_EMIT = 3'b100
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;

    // Decide commands and the next state
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        text_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                text_ready = 1'b1;
                if (text_valid)
                begin
                    cmd.step = 1'b1;
                    if (status.needs_div)
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIV;
                    end
                    else if (status.has_result)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    if (status.pend_note)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        cmd.load_whole = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[src/ringtone_text_note_parser_core.sv]
// ============================================================================
// Ringtone text note parser core
// Streams ringtone text and returns one word per completed note or text end.
// ============================================================================
//
//  Channel   Direction  Handshake                Word
//  text      in         text_valid/text_ready    tune_word_t (byte, first, last)
//  note      out        note_valid/note_ready    note_word_t (note fields, done)
//
//  Ordinary bytes are taken without further work. The header-closing colon is
//  accepted, then the serial divider runs, then the quotient is latched as the
//  whole-note time. A note-ending comma or a final byte inside a note is accepted,
//  the divider runs, then the result is loaded. A final byte with no note pending
//  is accepted and its result loaded; each load waits for a free output register.
//  Reset returns to the name section with default length 4, octave 6 and tempo 63.
//  A stalled result is held in the output register while the next byte is taken;
//  a further result load waits until that word is accepted.
//
module ringtone_text_note_parser_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  text_valid,
    output logic                  text_ready,
    input  rtnp_pkg::tune_word_t  text_word,
    output logic                  note_valid,
    input  logic                  note_ready,
    output rtnp_pkg::note_word_t  note_word
);

    rtnp_pkg::ctrl_cmd_t    cmd;
    rtnp_pkg::ctrl_status_t status;

    rtnp_controller u_controller (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .text_ready (text_ready),
        .status     (status),
        .cmd        (cmd)
    );

    rtnp_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .text_word  (text_word),
        .note_ready (note_ready),
        .status     (status),
        .note_valid (note_valid),
        .note_word  (note_word)
    );

endmodule

[src/rtnp_checker.sv]
// ============================================================================
// Ringtone text note parser port checker
// Watches the top-level ports for result word consistency and stalls.
// ============================================================================
`include "ringtone_text_note_parser_core_macros.svh"

module rtnp_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  note_valid,
    input logic                  note_ready,
    input rtnp_pkg::note_word_t  note_word
);

    // Hold a stalled result word
    `RTNP_ASSERT_NEXT(a_out_hold, note_valid && !note_ready, note_valid && $stable(note_word), "stalled result word changed")

    // Only the end of the text gives a word without a note
    `RTNP_ASSERT_SAME(a_empty_done, note_valid && !note_word.note_present, note_word.tune_done, "empty result before text end")

    // Clear every note field on an empty word
    `RTNP_ASSERT_SAME(a_empty_zero, note_valid && !note_word.note_present, (note_word.frequency_hz == 16'd0) && (note_word.duration_ms == 16'd0) && (note_word.gap_ms == 4'd0), "empty result carries note fields")

    // Long notes get the long gap
    `RTNP_ASSERT_SAME(a_gap_long, note_valid && note_word.note_present && (note_word.duration_ms > 16'd50), note_word.gap_ms == 4'd15, "long note without long gap")

endmodule

bind ringtone_text_note_parser_core rtnp_checker u_checker (.*);
